[hdl/crfa_pkg.sv]
package crfa_pkg;

    localparam int unsigned TOL_BITS = 24;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 24'd1000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_TEST,
        ST_DIV,
        ST_UPD,
        ST_FIX,
        ST_MUL,
        ST_OUT
    } crfa_state_t;

endpackage

[hdl/continued_fraction_rational_approx_top.sv]
// Rational approximation of an unsigned fixed-point value (INT_BITS.FRAC_BITS)
// by continued-fraction expansion.
// Input stream s_*: one request per value. Output stream m_*: one result per
// request, giving whole part, rounded numerator and convergent denominator.
// cfg_wr_en/cfg_wr_data write the tolerance reciprocal; write only while idle.
// Datapath: one restoring divider, one quotient bit per cycle. It
// alternates between s div tolerance (stop test) and s div r (next term).
// The convergent update term*d1 is accumulated from the quotient bits as
// they appear. The final product of the fractional part of the value and d1
// runs on a shift-add multiplier, one bit of d1 per cycle.
// s_tready is high only between requests; one request is in work at a time,
// so a new request waits until the last result is loaded for output.
// A finished result waits in the output register while m_tready is low; a new
// request is still accepted then, and its result waits until that register
// is free. Reset clears the valid flag, returns to idle and sets the
// tolerance reciprocal to 1000000.
module continued_fraction_rational_approx_top #(
    parameter int unsigned FRAC_BITS = 24,
    parameter int unsigned INT_BITS  = 8,
    localparam int unsigned VB       = INT_BITS + FRAC_BITS,
    localparam int unsigned DEN_BITS = FRAC_BITS + 1,
    localparam int unsigned IN_TW    = ((VB + 7) / 8) * 8,
    localparam int unsigned OUT_TW   = ((INT_BITS + 2 * DEN_BITS + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [IN_TW-1:0]               s_tdata,    // value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_TW-1:0]              m_tdata,    // whole_part, numerator, denominator
    input  logic                           cfg_wr_en,
    input  logic [crfa_pkg::TOL_BITS-1:0]  cfg_wr_data
);
    import crfa_pkg::*;

    localparam int unsigned DW = (VB > TOL_BITS) ? VB : TOL_BITS;
    localparam int unsigned CW = $clog2(VB);
    localparam int unsigned PW = 2 * DEN_BITS;

    crfa_state_t           state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [TOL_BITS-1:0]   tol_reg, tol_next;
    logic                  m_valid_reg, m_valid_next;

    logic [VB-1:0]         s_reg, s_next;
    logic [VB-1:0]         r_reg, r_next;
    logic [VB-1:0]         v_reg, v_next;
    logic [DEN_BITS-1:0]   d1_reg, d1_next;
    logic [DEN_BITS-1:0]   d2_reg, d2_next;
    logic [VB-1:0]         dvd_reg, dvd_next;
    logic [DW-1:0]         dsr_reg, dsr_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [DEN_BITS-1:0]   acc_reg, acc_next;
    logic [DEN_BITS-1:0]   mcand_reg, mcand_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [INT_BITS-1:0]   whole_reg, whole_next;
    logic [DEN_BITS-1:0]   num_reg, num_next;
    logic [DEN_BITS-1:0]   den_reg, den_next;

    logic [DW:0]           trial;
    logic [DW:0]           diff;
    logic                  qbit;
    logic [DW-1:0]         rem_step;
    logic [VB-1:0]         vm1;
    logic [DEN_BITS-1:0]   d1_fix;
    logic [PW-1:0]         rnd;
    logic                  out_load;

    // shared divider step
    always_comb begin
        trial    = {rem_reg, dvd_reg[VB-1]};
        diff     = trial - {1'b0, dsr_reg};
        qbit     = ~diff[DW];
        rem_step = qbit ? diff[DW-1:0] : trial[DW-1:0];
    end

    assign vm1    = v_reg - VB'(1);
    assign d1_fix = (d1_reg == '0) ? DEN_BITS'(1) : d1_reg;
    assign rnd    = prod_reg + (PW'(1) << (FRAC_BITS - 1));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TW'({den_reg, num_reg, whole_reg});

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        tol_next     = cfg_wr_en ? cfg_wr_data : tol_reg;
        m_valid_next = m_valid_reg;
        s_next       = s_reg;
        r_next       = r_reg;
        v_next       = v_reg;
        d1_next      = d1_reg;
        d2_next      = d2_reg;
        dvd_next     = dvd_reg;
        dsr_next     = dsr_reg;
        rem_next     = rem_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        prod_next    = prod_reg;
        whole_next   = whole_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        out_load     = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    s_next   = VB'(1) << FRAC_BITS;
                    r_next   = s_tdata[VB-1:0];
                    v_next   = s_tdata[VB-1:0];
                    d1_next  = DEN_BITS'(1);
                    d2_next  = '0;
                    dvd_next = VB'(1) << FRAC_BITS;
                    dsr_next = DW'(tol_reg);
                    rem_next = '0;
                    cnt_next = CW'(VB - 1);
                    state_next = (tol_reg == '0) ? ST_FIX : ST_CHK;
                end
            end
            ST_CHK: begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[VB-2:0], qbit};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                // dvd_reg holds floor(s / tolerance)
                if (r_reg > dvd_reg) begin
                    dvd_next   = s_reg;
                    dsr_next   = DW'(r_reg);
                    rem_next   = '0;
                    acc_next   = '0;
                    cnt_next   = CW'(VB - 1);
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_FIX;
                end
            end
            ST_DIV: begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[VB-2:0], qbit};
                acc_next = {acc_reg[DEN_BITS-2:0], 1'b0} + (qbit ? d1_reg : '0);
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                s_next     = r_reg;
                r_next     = rem_reg[VB-1:0];
                d2_next    = d1_reg;
                d1_next    = acc_reg + d2_reg;
                dvd_next   = r_reg;
                dsr_next   = DW'(tol_reg);
                rem_next   = '0;
                cnt_next   = CW'(VB - 1);
                state_next = ST_CHK;
            end
            ST_FIX: begin
                d1_next    = d1_fix;
                mcand_next = (v_reg == '0) ? '0
                           : DEN_BITS'(vm1[FRAC_BITS-1:0]) + DEN_BITS'(1);
                dvd_next   = VB'(d1_fix) << (VB - DEN_BITS);
                prod_next  = '0;
                cnt_next   = CW'(DEN_BITS - 1);
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next = {prod_reg[PW-2:0], 1'b0} + (dvd_reg[VB-1] ? PW'(mcand_reg) : '0);
                dvd_next  = {dvd_reg[VB-2:0], 1'b0};
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    whole_next   = (v_reg == '0) ? '0 : vm1[VB-1:FRAC_BITS];
                    num_next     = rnd[FRAC_BITS +: DEN_BITS];
                    den_next     = d1_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            tol_reg     <= TOL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tol_reg     <= tol_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg     <= s_next;
        r_reg     <= r_next;
        v_reg     <= v_next;
        d1_reg    <= d1_next;
        d2_reg    <= d2_next;
        dvd_reg   <= dvd_next;
        dsr_reg   <= dsr_next;
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
        whole_reg <= whole_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start work");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHK || state_reg == ST_DIV) |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");

    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (den_reg != '0))
        else $error("zero denominator delivered");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !out_load)
        else $error("pending result overwritten");
`endif

endmodule
